// ----- sv/im2col_pkg.sv -----
`timescale 1ns / 1ps
package im2col_pkg;

  // Limits of the configuration registers
  localparam int MAX_DIM      = 1024;
  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_KERNEL   = 15;

  localparam int DMAX = (MAX_DIM < 1024) ? MAX_DIM : 1024;
  localparam int CMAX = (MAX_CHANNELS < 1024) ? MAX_CHANNELS : 1024;
  localparam int KMAX = (MAX_KERNEL < 15) ? MAX_KERNEL : 15;

  // Field and register widths
  localparam int DIM_W = 11;
  localparam int KER_W = 4;
  localparam int CRI_W = 18;
  localparam int SRC_W = 30;
  localparam int DST_W = 38;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  // Shared divider: dividend is as wide as the kernel-row index
  localparam int DIV_W     = CRI_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING       = 3'd5;

  // Divider job selects
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_OUT_H = 2'd0;  // output height
  localparam div_sel_t DIV_OUT_W = 2'd1;  // output width
  localparam div_sel_t DIV_KCOL  = 2'd2;  // index / k
  localparam div_sel_t DIV_KROW  = 2'd3;  // (index / k) / k

  typedef struct packed {
    logic     accept;
    logic     nc_mul;
    logic     nc_fin;
    logic     div_start;
    div_sel_t div_sel;
    logic     clr;
    logic     step;
    logic     mul1;
    logic     mul2;
    logic     mul3;
    logic     out_load;
  } im2col_cmd_t;

  typedef struct packed {
    logic restart;
    logic div_done;
    logic out_busy;
  } im2col_sts_t;

endpackage

// ----- sv/im2col_address_generator.sv -----
`timescale 1ns / 1ps
// im2col address generator: every input word either restarts a pass (in_tdata[0] = 1) or
// advances it, and yields exactly one output word with the column-buffer destination index,
// the image source address and a padding flag telling the memory side to write zero. The
// walk runs kernel-row index (channel, kernel row, kernel column) outermost, then output
// row, then output column. Output sizes are computed from the registers at restart and
// held; an empty pass gives an all-zero word with valid_res low. The block works on one
// word at a time, paced by the shared bit-serial divider (each division takes a start
// step, one shift per quotient bit and a done step; two divisions split the kernel-row
// index on every word, two more size the output on restart). A new input word is taken
// only after the previous one has gone into the output register, where a finished word
// waits while the next input word is already accepted. Configuration writes are always
// taken (cfg_ready is high); write them only while no word is in flight.
module im2col_address_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [im2col_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [im2col_pkg::IN_TDATA_W-1:0]   in_tdata,   // [0] restart
  // Output words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [im2col_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [29:0] source_address,
                                                          // [67:30] destination_index
  output logic                                out_tlast,  // last
  output logic [im2col_pkg::OUT_TUSER_W-1:0]  out_tuser   // [0] is_padding, [1] valid_res
);
  import im2col_pkg::*;

  im2col_cmd_t cmd;
  im2col_sts_t sts;

  // Registers are plain flops with no side effects: always take a write
  assign cfg_ready = 1'b1;

  // Sequence each word: size the output on restart, advance, split, multiply, hand off
  im2col_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the configuration, walk counters, divider, address math and output register
  im2col_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_restart (in_tdata[0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- sv/im2col_div.sv -----
`timescale 1ns / 1ps
module im2col_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [im2col_pkg::DIV_W-1:0]   dividend,
  input  logic [im2col_pkg::KER_W-1:0]   divisor,
  output logic [im2col_pkg::DIV_W-1:0]   quotient,
  output logic [im2col_pkg::KER_W-1:0]   remainder,
  output logic                           done
);
  import im2col_pkg::*;

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [KER_W-1:0]     rem_r, rem_nxt;
  logic [KER_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [KER_W:0]       trial;
  logic [KER_W:0]       diff;
  logic                 fits;

  // Restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[KER_W-1:0] : trial[KER_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

// ----- sv/im2col_dp.sv -----
`timescale 1ns / 1ps
module im2col_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [im2col_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_restart,
  input  im2col_pkg::im2col_cmd_t             cmd,
  output im2col_pkg::im2col_sts_t             sts,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [im2col_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                out_tlast,
  output logic [im2col_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import im2col_pkg::*;

  // Configuration
  logic [DIM_W-1:0] img_h_r, img_w_r, chan_r;
  logic [KER_W-1:0] ksize_r, step_r, pad_r;
  logic [DIM_W-1:0] cfg_dim, cfg_chan;
  logic [KER_W-1:0] cfg_k4, cfg_ker, cfg_step;

  // Walk state
  logic [CRI_W-1:0] c_r;
  logic [DIM_W-1:0] h_r, w_r, oh_r, ow_r;
  logic [DST_W-1:0] dst_r;

  // Work registers
  logic             restart_r;
  logic [14:0]      ck_r;
  logic [CRI_W-1:0] nc_r;
  div_sel_t         sel_r;
  logic [CRI_W-1:0] q1_r, ch_r;
  logic [KER_W-1:0] kc_r, kr_r;
  logic [16:0]      row_r, col_r;
  logic [28:0]      hc_r;
  logic [SRC_W-1:0] a_r, src_r;
  logic             padf_r, lastf_r;

  // Output register
  logic             out_valid_r;
  logic [SRC_W-1:0] out_src_r;
  logic [DST_W-1:0] out_dst_r;
  logic             out_pad_r, out_last_r, out_vres_r;

  logic [DIM_W-1:0] span_h, span_w, k_ext, span_h_k, span_w_k;
  logic             h_short, w_short, live, at_last;
  logic [CRI_W:0]   c_p1;
  logic [DIM_W:0]   h_p1, w_p1;
  logic [DIV_W-1:0] div_dvd, div_quo;
  logic [KER_W-1:0] div_dvs, div_rem;
  logic             div_done;
  logic [14:0]      hs, ws;
  logic [16:0]      row_nxt, col_nxt;

  // Clamp a written value into its register's range
  always_comb begin
    cfg_k4 = cfg_data[KER_W-1:0];
    if (cfg_data == '0) cfg_dim = DIM_W'(1);
    else if (cfg_data > DIM_W'(DMAX)) cfg_dim = DIM_W'(DMAX);
    else cfg_dim = cfg_data;
    if (cfg_data == '0) cfg_chan = DIM_W'(1);
    else if (cfg_data > DIM_W'(CMAX)) cfg_chan = DIM_W'(CMAX);
    else cfg_chan = cfg_data;
    if (cfg_k4 == '0) cfg_ker = KER_W'(1);
    else if (cfg_k4 > KER_W'(KMAX)) cfg_ker = KER_W'(KMAX);
    else cfg_ker = cfg_k4;
    cfg_step = (cfg_k4 == '0) ? KER_W'(1) : cfg_k4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_h_r <= DIM_W'(1);
      img_w_r <= DIM_W'(1);
      chan_r  <= DIM_W'(1);
      ksize_r <= KER_W'(1);
      step_r  <= KER_W'(1);
      pad_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_HEIGHT:  img_h_r <= cfg_dim;
        REG_IMAGE_WIDTH:   img_w_r <= cfg_dim;
        REG_CHANNEL_COUNT: chan_r  <= cfg_chan;
        REG_KERNEL_SIZE:   ksize_r <= cfg_ker;
        REG_STEP_SIZE:     step_r  <= cfg_step;
        REG_PADDING:       pad_r   <= cfg_k4;
        default: ;
      endcase
    end
  end

  // Output size operands and end-of-pass test
  always_comb begin
    k_ext    = DIM_W'(ksize_r);
    span_h   = img_h_r + DIM_W'({pad_r, 1'b0});
    span_w   = img_w_r + DIM_W'({pad_r, 1'b0});
    span_h_k = span_h - k_ext;
    span_w_k = span_w - k_ext;
    h_short  = (span_h < k_ext);
    w_short  = (span_w < k_ext);
    live     = (oh_r != '0) && (ow_r != '0);
    c_p1     = {1'b0, c_r} + (CRI_W+1)'(1);
    h_p1     = {1'b0, h_r} + (DIM_W+1)'(1);
    w_p1     = {1'b0, w_r} + (DIM_W+1)'(1);
    at_last  = (c_p1 >= {1'b0, nc_r}) && (h_p1 >= {1'b0, oh_r}) &&
               (w_p1 >= {1'b0, ow_r});
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_OUT_H: begin div_dvd = DIV_W'(span_h_k); div_dvs = step_r;  end
      DIV_OUT_W: begin div_dvd = DIV_W'(span_w_k); div_dvs = step_r;  end
      DIV_KCOL:  begin div_dvd = c_r;              div_dvs = ksize_r; end
      DIV_KROW:  begin div_dvd = q1_r;             div_dvs = ksize_r; end
      default:   begin div_dvd = c_r;              div_dvs = ksize_r; end
    endcase
  end

  im2col_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Walk state: sizes latched at restart, counters advance in walk order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r   <= '0;
      h_r   <= '0;
      w_r   <= '0;
      oh_r  <= '0;
      ow_r  <= '0;
      dst_r <= '0;
    end else begin
      if (div_done) begin
        if (sel_r == DIV_OUT_H) begin
          oh_r <= h_short ? '0 : div_quo[DIM_W-1:0] + DIM_W'(1);
        end
        if (sel_r == DIV_OUT_W) begin
          ow_r <= w_short ? '0 : div_quo[DIM_W-1:0] + DIM_W'(1);
        end
      end
      if (cmd.clr) begin
        c_r   <= '0;
        h_r   <= '0;
        w_r   <= '0;
        dst_r <= '0;
      end else if (cmd.step && live) begin
        if (at_last) begin
          c_r   <= '0;
          h_r   <= '0;
          w_r   <= '0;
          dst_r <= '0;
        end else begin
          if (w_p1 >= {1'b0, ow_r}) begin
            w_r <= '0;
            if (h_p1 >= {1'b0, oh_r}) begin
              h_r <= '0;
              c_r <= c_p1[CRI_W-1:0];
            end else begin
              h_r <= h_p1[DIM_W-1:0];
            end
          end else begin
            w_r <= w_p1[DIM_W-1:0];
          end
          dst_r <= dst_r + DST_W'(1);
        end
      end
    end
  end

  always_comb begin
    hs      = 15'(h_r) * 15'(step_r);
    ws      = 15'(w_r) * 15'(step_r);
    row_nxt = 17'(hs) + 17'(kr_r) - 17'(pad_r);
    col_nxt = 17'(ws) + 17'(kc_r) - 17'(pad_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) restart_r <= in_restart;
    if (cmd.nc_mul) ck_r <= 15'(chan_r) * 15'(ksize_r);
    if (cmd.nc_fin) nc_r <= CRI_W'(ck_r) * CRI_W'(ksize_r);
    if (cmd.div_start) sel_r <= cmd.div_sel;
    if (div_done && sel_r == DIV_KCOL) begin
      q1_r <= div_quo;
      kc_r <= div_rem;
    end
    if (div_done && sel_r == DIV_KROW) begin
      ch_r <= div_quo;
      kr_r <= div_rem;
    end
    if (cmd.mul1) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      hc_r  <= 29'(img_h_r) * 29'(ch_r);
    end
    if (cmd.mul2) begin
      a_r     <= SRC_W'(row_r[15:0]) + SRC_W'(hc_r);
      padf_r  <= row_r[16] || col_r[16] || (row_r[15:0] >= 16'(img_h_r)) ||
                 (col_r[15:0] >= 16'(img_w_r));
      lastf_r <= at_last;
    end
    if (cmd.mul3) begin
      src_r <= SRC_W'(col_r[15:0]) + SRC_W'(img_w_r) * a_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_src_r  <= (live && !padf_r) ? src_r : '0;
      out_dst_r  <= live ? dst_r : '0;
      out_pad_r  <= live && padf_r;
      out_last_r <= live && lastf_r;
      out_vres_r <= live;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DST_W-SRC_W){1'b0}}, out_dst_r, out_src_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_vres_r, out_pad_r};

  assign sts.restart  = restart_r;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

// ----- sv/im2col_ctrl.sv -----
`timescale 1ns / 1ps
module im2col_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  im2col_pkg::im2col_sts_t  sts,
  output im2col_pkg::im2col_cmd_t  cmd
);
  import im2col_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NC1   = 4'd1;
  localparam logic [3:0] S_NC2   = 4'd2;
  localparam logic [3:0] S_DIVH  = 4'd3;
  localparam logic [3:0] S_WAITH = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_WAITW = 4'd6;
  localparam logic [3:0] S_STEP  = 4'd7;
  localparam logic [3:0] S_DIVC  = 4'd8;
  localparam logic [3:0] S_WAITC = 4'd9;
  localparam logic [3:0] S_DIVQ  = 4'd10;
  localparam logic [3:0] S_WAITQ = 4'd11;
  localparam logic [3:0] S_MUL1  = 4'd12;
  localparam logic [3:0] S_MUL2  = 4'd13;
  localparam logic [3:0] S_MUL3  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_NC1;
        end
      end
      S_NC1: begin
        cmd.nc_mul = 1'b1;
        state_nxt  = S_NC2;
      end
      S_NC2: begin
        cmd.nc_fin = 1'b1;
        state_nxt  = sts.restart ? S_DIVH : S_STEP;
      end
      S_DIVH: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_OUT_H;
        cmd.clr       = 1'b1;
        state_nxt     = S_WAITH;
      end
      S_WAITH: if (sts.div_done) state_nxt = S_DIVW;
      S_DIVW: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_OUT_W;
        state_nxt     = S_WAITW;
      end
      S_WAITW: if (sts.div_done) state_nxt = S_DIVC;
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_DIVC;
      end
      S_DIVC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_KCOL;
        state_nxt     = S_WAITC;
      end
      S_WAITC: if (sts.div_done) state_nxt = S_DIVQ;
      S_DIVQ: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_KROW;
        state_nxt     = S_WAITQ;
      end
      S_WAITQ: if (sts.div_done) state_nxt = S_MUL1;
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// ----- sv/im2col_chk.sv -----
`timescale 1ns / 1ps
module im2col_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [im2col_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                                out_tlast,
  input logic [im2col_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import im2col_pkg::*;

  // Output stays empty coming out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  // One word in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // An empty pass gives an all-zero word
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == '0 && !out_tlast && !out_tuser[0])
    else $error("empty pass word not zero");

  // Padding words carry a zero source address
  a_pad_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[SRC_W-1:0] == '0)
    else $error("padding word with nonzero source address");

endmodule

bind im2col_address_generator im2col_chk u_im2col_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- tb/im2col_address_generator_tb.sv -----
`timescale 1ns / 1ps
module im2col_address_generator_tb;
  import im2col_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          END_SETTLE  = 100;  // longer than a restart word takes to come through
  localparam int          STEP_MAX    = 15;
  localparam int          RANDOM_RUN  = 150;  // input words per idling profile
  // Register indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef longint unsigned u64_t;

  // One output word as the block should present it
  typedef struct packed {
    logic [SRC_W-1:0] source_address;
    logic [DST_W-1:0] destination_index;
    logic             is_padding;
    logic             last;
    logic             valid_res;
  } addr_word_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Live register copies, at their reset values
  logic [DIM_W-1:0] img_rows   = 1;
  logic [DIM_W-1:0] img_cols   = 1;
  logic [DIM_W-1:0] img_chans  = 1;
  logic [KER_W-1:0] ker_side   = 1;
  logic [KER_W-1:0] stride     = 1;
  logic [KER_W-1:0] pad_border = 0;

  // Walk position and the output sizes latched at restart
  logic [CRI_W-1:0] walk_kidx = '0;
  logic [DIM_W-1:0] walk_row  = '0;
  logic [DIM_W-1:0] walk_col  = '0;
  logic [DIM_W-1:0] rows_out  = '0;
  logic [DIM_W-1:0] cols_out  = '0;
  logic [DST_W-1:0] dest_idx  = '0;

  addr_word_t pending_words[$];
  addr_word_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int cycle_count   = 0;
  int words_sent    = 0;
  int restarts_sent = 0;
  int cfg_writes    = 0;
  int words_checked = 0;
  int pads_seen     = 0;
  int lasts_seen    = 0;
  int empty_seen    = 0;

  im2col_address_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] restart
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [29:0] source_address, [67:30] destination_index
    .out_tlast  (out_tlast),   // last
    .out_tuser  (out_tuser)    // [0] is_padding, [1] valid_res
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: drop ready at random per the current idling profile
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("cycle limit hit with %0d words outstanding", pending_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Address walk predictor
  // ---------------------------------------------------------------------------

  // Zero becomes one, anything above the limit becomes the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return DIM_W'(1);
    if (v > hi) return hi[DIM_W-1:0];
    return v[DIM_W-1:0];
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_IMAGE_HEIGHT:  img_rows   = clamp_dim(value, DMAX);
      REG_IMAGE_WIDTH:   img_cols   = clamp_dim(value, DMAX);
      REG_CHANNEL_COUNT: img_chans  = clamp_dim(value, CMAX);
      REG_KERNEL_SIZE:   ker_side   = KER_W'(clamp_dim(value[KER_W-1:0], KMAX));
      REG_STEP_SIZE:     stride     = KER_W'(clamp_dim(value[KER_W-1:0], STEP_MAX));
      REG_PADDING:       pad_border = value[KER_W-1:0];
      default: ;  // no register here: write is dropped
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] out_dim(input logic [DIM_W-1:0] dim);
    int unsigned span;
    span = dim + 2 * pad_border;
    if (span < ker_side) return '0;
    return DIM_W'((span - ker_side) / stride + 1);
  endfunction

  // Pass end is judged on the live channel and kernel registers
  function automatic bit at_pass_end();
    int unsigned kernel_rows;
    kernel_rows = img_chans * ker_side * ker_side;
    return (walk_kidx + 1 >= kernel_rows) && (walk_row + 1 >= rows_out) &&
           (walk_col + 1 >= cols_out);
  endfunction

  function automatic u64_t pass_length();
    return u64_t'(img_chans) * ker_side * ker_side * rows_out * cols_out;
  endfunction

  // Advance or restart the walk and build the word the block should emit
  function automatic addr_word_t walk_step(input logic restart);
    addr_word_t  w;
    int unsigned kcol, krow, chan;
    longint      row, col;
    u64_t        addr;
    w = '0;
    if (restart) begin
      rows_out  = out_dim(img_rows);
      cols_out  = out_dim(img_cols);
      walk_kidx = '0;
      walk_row  = '0;
      walk_col  = '0;
      dest_idx  = '0;
    end else if (rows_out != 0 && cols_out != 0) begin
      if (at_pass_end()) begin
        // wrap to the first element, as a new pass would
        walk_kidx = '0;
        walk_row  = '0;
        walk_col  = '0;
        dest_idx  = '0;
      end else begin
        walk_col = walk_col + 1'b1;
        if (walk_col >= cols_out) begin
          walk_col = '0;
          walk_row = walk_row + 1'b1;
          if (walk_row >= rows_out) begin
            walk_row  = '0;
            walk_kidx = walk_kidx + 1'b1;
          end
        end
        dest_idx = dest_idx + 1'b1;
      end
    end
    if (rows_out == 0 || cols_out == 0) return w;  // empty pass: all-zero word

    kcol = walk_kidx % ker_side;
    krow = (walk_kidx / ker_side) % ker_side;
    chan = walk_kidx / ker_side / ker_side;
    row  = longint'(krow) + longint'(walk_row) * longint'(stride) - longint'(pad_border);
    col  = longint'(kcol) + longint'(walk_col) * longint'(stride) - longint'(pad_border);
    w.is_padding = (row < 0) || (col < 0) || (row >= longint'(img_rows)) ||
                   (col >= longint'(img_cols));
    if (!w.is_padding) begin
      addr = u64_t'(col) + u64_t'(img_cols) * (u64_t'(row) + u64_t'(img_rows) * chan);
      w.source_address = addr[SRC_W-1:0];
    end
    w.destination_index = dest_idx;
    w.last              = at_pass_end();
    w.valid_res         = 1'b1;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Output checker: compare every accepted word with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("output word with nothing predicted: tdata=%h", out_tdata);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (want.is_padding) pads_seen++;
        if (want.last) lasts_seen++;
        if (!want.valid_res) empty_seen++;
        if (out_tdata[SRC_W-1:0] !== want.source_address) begin
          $error("source_address: expected %0d, got %0d",
                 want.source_address, out_tdata[SRC_W-1:0]);
          fail_count++;
        end
        if (out_tdata[SRC_W+DST_W-1:SRC_W] !== want.destination_index) begin
          $error("destination_index: expected %0d, got %0d",
                 want.destination_index, out_tdata[SRC_W+DST_W-1:SRC_W]);
          fail_count++;
        end
        if (out_tuser[0] !== want.is_padding) begin
          $error("is_padding: expected %0d, got %0d", want.is_padding, out_tuser[0]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          fail_count++;
        end
        if (out_tuser[1] !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers; all of them are entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // Send one input word. Valid stays high on return, so back-to-back words see it
  // drop only when the idling profile puts a gap between them; drain_words lowers it.
  task automatic send_word(input logic restart);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
    pending_words.push_back(walk_step(restart));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (restart) restarts_sent++;
  endtask

  // Hold off until every predicted word has come back
  task automatic drain_words();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    apply_reg(idx, value);
    cfg_writes++;
  endtask

  // Write all six registers back to back; only call with the block idle
  task automatic load_config(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
                             input logic [CFG_DATA_W-1:0] chans, input logic [CFG_DATA_W-1:0] ksz,
                             input logic [CFG_DATA_W-1:0] stp, input logic [CFG_DATA_W-1:0] pad,
                             input bit with_unused);
    write_reg(REG_IMAGE_HEIGHT, rows);
    write_reg(REG_IMAGE_WIDTH, cols);
    write_reg(REG_CHANNEL_COUNT, chans);
    if (with_unused) write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom));
    write_reg(REG_KERNEL_SIZE, ksz);
    write_reg(REG_STEP_SIZE, stp);
    write_reg(REG_PADDING, pad);
    if (with_unused) write_reg(REG_UNUSED_HI, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Advance with no restart since reset: sizes are zero, so the word is empty
  task automatic test_idle_before_restart();
    send_word(1'b0);
    drain_words();
  endtask

  // Zero, oversize and wide values clamp; writes to unused indexes are dropped
  task automatic test_register_clamps();
    load_config(11'd0, 11'h7FF, 11'h7FF, 11'h7F0, 11'd0, 11'h7FF, 1'b1);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    drain_words();
  endtask

  // Largest image, kernel, stride and border, then the one-element pass
  task automatic test_extreme_sizes();
    load_config(CFG_DATA_W'(DMAX), CFG_DATA_W'(DMAX), CFG_DATA_W'(CMAX), CFG_DATA_W'(KMAX),
                CFG_DATA_W'(STEP_MAX), 11'd15, 1'b0);
    send_word(1'b1);
    send_word(1'b0);
    drain_words();
    load_config(11'd1, 11'd1, 11'd1, 11'd1, 11'd1, 11'd0, 1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    drain_words();
  endtask

  // Kernel larger than the padded image: no output positions at all
  task automatic test_empty_pass();
    load_config(11'd1, 11'd5, 11'd1, 11'd3, 11'd1, 11'd0, 1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    drain_words();
  endtask

  // Eight-element pass, mostly border; advance once past its end to wrap
  task automatic test_padding_and_wrap();
    load_config(11'd1, 11'd1, 11'd2, 11'd2, 11'd2, 11'd1, 1'b0);
    send_word(1'b1);
    repeat (8) send_word(1'b0);
    drain_words();
  endtask

  // Change width and kernel between two words of a pass: sizes stay latched
  task automatic test_midpass_change();
    load_config(11'd3, 11'd3, 11'd1, 11'd1, 11'd1, 11'd0, 1'b0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    drain_words();
    load_config(11'd3, 11'd2, 11'd1, 11'd2, 11'd1, 11'd0, 1'b0);
    send_word(1'b0);
    send_word(1'b0);
    drain_words();
  endtask

  // Mostly whole passes over small images with random shape; now and then
  // raw or extreme register values, a pass continued under a new setting,
  // or a stray restart in the middle of a run.
  task automatic test_random_passes(input int send_pct, input int recv_pct, input int n_words);
    int                    sent;
    int                    run_len;
    u64_t                  plen;
    logic [CFG_DATA_W-1:0] rows, cols, chans, ksz, stp, pad;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(5) != 0) begin
        case ($urandom_range(9))
          0: begin  // raw values, clamped by the block
            rows  = CFG_DATA_W'($urandom);
            cols  = CFG_DATA_W'($urandom);
            chans = CFG_DATA_W'($urandom);
            ksz   = CFG_DATA_W'($urandom);
            stp   = CFG_DATA_W'($urandom);
            pad   = CFG_DATA_W'($urandom);
          end
          1: begin  // each register at one end of its range
            rows  = $urandom_range(1) ? CFG_DATA_W'(DMAX) : CFG_DATA_W'(1);
            cols  = $urandom_range(1) ? CFG_DATA_W'(DMAX) : CFG_DATA_W'(1);
            chans = $urandom_range(1) ? CFG_DATA_W'(CMAX) : CFG_DATA_W'(1);
            ksz   = $urandom_range(1) ? CFG_DATA_W'(KMAX) : CFG_DATA_W'(1);
            stp   = $urandom_range(1) ? CFG_DATA_W'(STEP_MAX) : CFG_DATA_W'(1);
            pad   = $urandom_range(1) ? CFG_DATA_W'(15) : CFG_DATA_W'(0);
          end
          default: begin
            rows  = CFG_DATA_W'($urandom_range(8, 1));
            cols  = CFG_DATA_W'($urandom_range(8, 1));
            chans = CFG_DATA_W'($urandom_range(3, 1));
            ksz   = CFG_DATA_W'($urandom_range(3, 1));
            stp   = CFG_DATA_W'($urandom_range(3, 1));
            pad   = CFG_DATA_W'($urandom_range(2, 0));
          end
        endcase
        load_config(rows, cols, chans, ksz, stp, pad, $urandom_range(7) == 0);
      end
      // skip the restart now and then: the old pass goes on under new registers
      if ($urandom_range(6) != 0) begin
        send_word(1'b1);
        sent++;
      end
      plen = pass_length();
      if (plen != 0 && plen <= 80 && $urandom_range(2) != 0)
        run_len = int'(plen) + $urandom_range(3);
      else
        run_len = $urandom_range(25, 3);
      repeat (run_len) begin
        send_word($urandom_range(19) == 0);
        sent++;
      end
      drain_words();
    end
  endtask

  initial begin
    send_idle_pct = 9;
    recv_idle_pct = 54;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_before_restart();
    test_register_clamps();
    test_extreme_sizes();
    test_empty_pass();
    test_padding_and_wrap();
    test_midpass_change();

    test_random_passes(9, 54, RANDOM_RUN);
    test_random_passes(54, 9, RANDOM_RUN);
    test_random_passes(0, 0, RANDOM_RUN);

    drain_words();
    repeat (END_SETTLE) @(negedge clk);

    $display("Covered %0d input words (%0d restarts) and %0d register writes.",
             words_sent, restarts_sent, cfg_writes);
    $display("Checked %0d output words: %0d border, %0d pass ends, %0d empty.",
             words_checked, pads_seen, lasts_seen, empty_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/im2col_pkg.sv
sv/im2col_div.sv
sv/im2col_dp.sv
sv/im2col_ctrl.sv
sv/im2col_address_generator.sv
sv/im2col_chk.sv
tb/im2col_address_generator_tb.sv
